@@ hdl/aps_pkg.sv @@
// Shared types, constants and helper functions of the arm position sequencer.
package aps_pkg;

    // Widths of the angle datapath, the transit countdown, the inputs and the codes
    localparam int ANGLE_BITS = 12;
    localparam int WAIT_BITS  = 10;
    localparam int TICKS_BITS = 10;
    localparam int AXIS_W     = 12;
    localparam int BTN_W      = 7;
    localparam int POS_W      = 3;
    localparam int LEVEL_W    = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_W      = (ANGLE_BITS > TICKS_BITS) ? ANGLE_BITS : TICKS_BITS;
    localparam int NUM_BASE   = 6;

    localparam int ANG_FS_INT = (1 << ANGLE_BITS) - 1;
    localparam int WAIT_MAX   = (1 << WAIT_BITS) - 1;
    localparam logic [ANGLE_BITS-1:0] ANG_FS = ANGLE_BITS'(ANG_FS_INT);

    // Fine-adjust arithmetic: product, rounding, floor shift, clamp
    localparam int PROD_W     = AXIS_W + ANGLE_BITS + 1;
    localparam int SUM_W      = ANGLE_BITS + 3;
    localparam int AXIS_SHIFT = AXIS_W - 1;
    localparam int ROUND_HALF = 1 << (AXIS_SHIFT - 1);
    localparam int GAIN_ARM_INT    = (ANG_FS_INT * 2 + 5) / 10;
    localparam int GAIN_GROUND_INT = (ANG_FS_INT * 2 + 15) / 30;

    // Reset values, scaled from the 12-bit figures to the angle width
    localparam int RST_MIDDLE_LOW = (1663 * ANG_FS_INT + 2047) / 4095;
    localparam int RST_TOP_LOW    = (3423 * ANG_FS_INT + 2047) / 4095;
    localparam int RST_MIDDLE_TOP = (2801 * ANG_FS_INT + 2047) / 4095;
    localparam int RST_TOP_TOP    = (3112 * ANG_FS_INT + 2047) / 4095;
    localparam int RST_GROUND     = (2932 * ANG_FS_INT + 2047) / 4095;
    localparam int RST_FOLD       = (480 * ANG_FS_INT + 2047) / 4095;
    localparam int RST_LOW_LIMIT  = (2867 * ANG_FS_INT + 2047) / 4095;
    localparam int RST_TRANSIT    = 50;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_MIDDLE_LOW = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_TOP_LOW    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_MIDDLE_TOP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_TOP_TOP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_GROUND     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_FOLD       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_LEVEL_LIMIT  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_TRANSIT_TICKS    = 3'd7;

    // Arm position codes
    localparam logic [POS_W-1:0] POS_MIDDLE_LOW = 3'd1;
    localparam logic [POS_W-1:0] POS_TOP_LOW    = 3'd2;
    localparam logic [POS_W-1:0] POS_MIDDLE_TOP = 3'd3;
    localparam logic [POS_W-1:0] POS_TOP_TOP    = 3'd4;
    localparam logic [POS_W-1:0] POS_GROUND     = 3'd5;
    localparam logic [POS_W-1:0] POS_FOLD       = 3'd6;

    // Pneumatic levels
    localparam logic [LEVEL_W-1:0] LEVEL_DOWN    = 2'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_MID_LOW = 2'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_MID_TOP = 2'd2;
    localparam logic [LEVEL_W-1:0] LEVEL_TOP     = 2'd3;

    // Button bits
    localparam int BTN_TOP_TOP    = 0;
    localparam int BTN_TOP_LOW    = 1;
    localparam int BTN_MIDDLE_TOP = 2;
    localparam int BTN_MIDDLE_LOW = 3;
    localparam int BTN_GROUND     = 4;
    localparam int BTN_CLAW       = 5;
    localparam int BTN_FOLD       = 6;

    typedef struct packed {
        logic [BTN_W-1:0]             buttons;
        logic signed [AXIS_W-1:0]     fine_axis;
        logic [ANGLE_BITS-1:0]        arm_position;
    } t_item;

    typedef struct packed {
        logic [ANGLE_BITS-1:0] elbow_target;
        logic                  low_valve;
        logic                  high_valve;
        logic                  claw_closed;
        logic [POS_W-1:0]      position_code;
        logic                  in_transit;
    } t_result;

    typedef struct packed {
        logic [NUM_BASE-1:0][ANGLE_BITS-1:0] base;
        logic [ANGLE_BITS-1:0]               low_limit;
        logic [TICKS_BITS-1:0]               transit_ticks;
    } t_cfg;

    function automatic logic [LEVEL_W-1:0] level_of(input logic [POS_W-1:0] pos);
        logic [LEVEL_W-1:0] lvl;
        case (pos)
            POS_MIDDLE_LOW: lvl = LEVEL_MID_LOW;
            POS_MIDDLE_TOP: lvl = LEVEL_MID_TOP;
            POS_TOP_LOW:    lvl = LEVEL_TOP;
            POS_TOP_TOP:    lvl = LEVEL_TOP;
            default:        lvl = LEVEL_DOWN;
        endcase
        return lvl;
    endfunction

    function automatic logic low_valve_of(input logic [LEVEL_W-1:0] lvl);
        return (lvl == LEVEL_MID_LOW) || (lvl == LEVEL_TOP);
    endfunction

    function automatic logic high_valve_of(input logic [LEVEL_W-1:0] lvl);
        return (lvl == LEVEL_DOWN) || (lvl == LEVEL_MID_LOW);
    endfunction

    // Saturate the transit setting to what the countdown holds
    function automatic logic [WAIT_BITS-1:0] sat_wait(input logic [TICKS_BITS-1:0] ticks);
        logic [31:0] wide;
        wide = 32'(ticks);
        if (wide > 32'(WAIT_MAX)) begin
            return WAIT_BITS'(WAIT_MAX);
        end
        return WAIT_BITS'(wide);
    endfunction

endpackage

@@ hdl/aps_if.sv @@
// Handshake channels of the arm position sequencer: input, result and configuration.
interface aps_item_if;
    import aps_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [BTN_W-1:0]         buttons;
    logic signed [AXIS_W-1:0] fine_axis;
    logic [ANGLE_BITS-1:0]    arm_position;

    modport source (output valid, output buttons, output fine_axis, output arm_position,
                    input ready);
    modport sink   (input valid, input buttons, input fine_axis, input arm_position,
                    output ready);
endinterface

interface aps_result_if;
    import aps_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [ANGLE_BITS-1:0] elbow_target;
    logic                  low_valve;
    logic                  high_valve;
    logic                  claw_closed;
    logic [POS_W-1:0]      position_code;
    logic                  in_transit;

    modport source (output valid, output elbow_target, output low_valve, output high_valve,
                    output claw_closed, output position_code, output in_transit,
                    input ready);
    modport sink   (input valid, input elbow_target, input low_valve, input high_valve,
                    input claw_closed, input position_code, input in_transit,
                    output ready);
endinterface

interface aps_cfg_if;
    import aps_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hdl/aps_cfg_regs.sv @@
// Configuration register file: base angles, low-level limit and transit wait.
module aps_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    aps_cfg_if.sink       i_cfg,
    output aps_pkg::t_cfg o_cfg
);
    import aps_pkg::*;

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base[REG_ANGLE_MIDDLE_LOW] <= ANGLE_BITS'(RST_MIDDLE_LOW);
            r_cfg.base[REG_ANGLE_TOP_LOW]    <= ANGLE_BITS'(RST_TOP_LOW);
            r_cfg.base[REG_ANGLE_MIDDLE_TOP] <= ANGLE_BITS'(RST_MIDDLE_TOP);
            r_cfg.base[REG_ANGLE_TOP_TOP]    <= ANGLE_BITS'(RST_TOP_TOP);
            r_cfg.base[REG_ANGLE_GROUND]     <= ANGLE_BITS'(RST_GROUND);
            r_cfg.base[REG_ANGLE_FOLD]       <= ANGLE_BITS'(RST_FOLD);
            r_cfg.low_limit                  <= ANGLE_BITS'(RST_LOW_LIMIT);
            r_cfg.transit_ticks              <= TICKS_BITS'(RST_TRANSIT);
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_ANGLE_MIDDLE_LOW,
                REG_ANGLE_TOP_LOW,
                REG_ANGLE_MIDDLE_TOP,
                REG_ANGLE_TOP_TOP,
                REG_ANGLE_GROUND,
                REG_ANGLE_FOLD: begin
                    r_cfg.base[i_cfg.index] <= i_cfg.data[ANGLE_BITS-1:0];
                end
                REG_LOW_LEVEL_LIMIT: begin
                    r_cfg.low_limit <= i_cfg.data[ANGLE_BITS-1:0];
                end
                REG_TRANSIT_TICKS: begin
                    r_cfg.transit_ticks <= i_cfg.data[TICKS_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end
endmodule

@@ hdl/aps_in_reg.sv @@
// Input register: capture one tick word and hold it until the step logic takes it.
module aps_in_reg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    aps_item_if.sink       i_item,
    input  logic           i_take,
    output logic           o_valid,
    output aps_pkg::t_item o_word
);
    import aps_pkg::*;

    logic  r_valid;
    t_item r_word;

    // Refill in the same cycle that the held word moves on
    assign i_item.ready = !r_valid || i_take;
    assign o_valid      = r_valid;
    assign o_word       = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_word.buttons      <= i_item.buttons;
            r_word.fine_axis    <= i_item.fine_axis;
            r_word.arm_position <= i_item.arm_position;
        end
    end
endmodule

@@ hdl/aps_core.sv @@
// Step logic: sequencer state, elbow target arithmetic and the result register.
module aps_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  aps_pkg::t_item i_word,
    input  aps_pkg::t_cfg  i_cfg,
    output logic           o_take,
    aps_result_if.source   o_result
);
    import aps_pkg::*;

    localparam logic signed [SUM_W-1:0] SUM_FS = SUM_W'(ANG_FS_INT);

    logic [POS_W-1:0]      r_pos, n_pos;
    logic [LEVEL_W-1:0]    r_level, n_level;
    logic                  r_transit, n_transit;
    logic [WAIT_BITS-1:0]  r_cnt, n_cnt;
    logic                  r_vlow, n_vlow;
    logic                  r_vhigh, n_vhigh;
    logic [ANGLE_BITS-1:0] r_elbow, n_elbow;
    logic                  r_toggle, n_toggle;
    logic                  r_pressed, n_pressed;
    logic                  r_out_valid;
    t_result               r_out_word;

    logic [LEVEL_W-1:0]       level;
    logic [ANGLE_BITS-1:0]    lim;
    logic [ANGLE_BITS-1:0]    base;
    logic [ANGLE_BITS-1:0]    gain;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] rnd;
    logic signed [SUM_W-1:0]  sum;
    logic [ANGLE_BITS-1:0]    want;
    logic [ANGLE_BITS-1:0]    want_cap;
    logic [ANGLE_BITS-1:0]    want_low;
    logic                     loaded;

    assign o_take = i_valid && (!r_out_valid || o_result.ready);

    // Per-position base angle, gain and ceiling
    always_comb begin
        level = level_of(r_pos);
        case (r_pos)
            POS_MIDDLE_LOW: begin
                base = i_cfg.base[REG_ANGLE_MIDDLE_LOW];
                gain = ANGLE_BITS'(GAIN_ARM_INT);
                lim  = ANG_FS;
            end
            POS_TOP_LOW: begin
                base = i_cfg.base[REG_ANGLE_TOP_LOW];
                gain = ANGLE_BITS'(GAIN_ARM_INT);
                lim  = ANG_FS;
            end
            POS_MIDDLE_TOP: begin
                base = i_cfg.base[REG_ANGLE_MIDDLE_TOP];
                gain = ANGLE_BITS'(GAIN_ARM_INT);
                lim  = ANG_FS;
            end
            POS_TOP_TOP: begin
                base = i_cfg.base[REG_ANGLE_TOP_TOP];
                gain = ANGLE_BITS'(GAIN_ARM_INT);
                lim  = ANG_FS;
            end
            POS_GROUND: begin
                base = i_cfg.base[REG_ANGLE_GROUND];
                gain = ANGLE_BITS'(GAIN_GROUND_INT);
                lim  = i_cfg.low_limit;
            end
            default: begin
                base = i_cfg.base[REG_ANGLE_FOLD];
                gain = '0;
                lim  = i_cfg.low_limit;
            end
        endcase
    end

    // Elbow target: base plus rounded axis times gain, clamped to zero and full scale, then capped
    always_comb begin
        prod = PROD_W'(i_word.fine_axis) * PROD_W'($signed({1'b0, gain}));
        rnd  = prod + PROD_W'(ROUND_HALF);
        sum  = SUM_W'($signed(rnd[PROD_W-1:AXIS_SHIFT])) + SUM_W'($signed({1'b0, base}));
        if (sum[SUM_W-1]) begin
            want = '0;
        end else if (sum > SUM_FS) begin
            want = ANG_FS;
        end else begin
            want = sum[ANGLE_BITS-1:0];
        end
        want_cap = (want < lim) ? want : lim;
        want_low = (want < i_cfg.low_limit) ? want : i_cfg.low_limit;
    end

    // Next state of the sequencer
    always_comb begin
        n_pos     = r_pos;
        n_level   = r_level;
        n_transit = r_transit;
        n_cnt     = r_cnt;
        n_vlow    = r_vlow;
        n_vhigh   = r_vhigh;
        n_elbow   = r_elbow;
        n_toggle  = r_toggle;
        n_pressed = r_pressed;
        loaded    = 1'b0;

        if (level > r_level) begin
            if (!r_transit) begin
                // switch valves first, then start the wait
                n_vlow    = low_valve_of(level);
                n_vhigh   = high_valve_of(level);
                n_transit = 1'b1;
                n_cnt     = sat_wait(i_cfg.transit_ticks);
                loaded    = 1'b1;
            end else if (r_cnt == '0) begin
                n_transit = 1'b0;
                n_level   = level;
                n_elbow   = want_cap;
            end else begin
                n_elbow = want_low;
            end
        end else if (i_word.arm_position > lim) begin
            n_elbow = lim;
        end else begin
            n_vlow  = low_valve_of(level);
            n_vhigh = high_valve_of(level);
            n_level = level;
            n_elbow = want_cap;
        end

        if (!loaded && (r_cnt != '0)) begin
            n_cnt = r_cnt - 1'b1;
        end

        if (i_word.buttons[BTN_CLAW] && !r_pressed) begin
            n_pressed = 1'b1;
            n_toggle  = !r_toggle;
        end else if (!i_word.buttons[BTN_CLAW]) begin
            n_pressed = 1'b0;
        end

        if (i_word.buttons[BTN_MIDDLE_LOW]) begin
            n_pos = POS_MIDDLE_LOW;
        end else if (i_word.buttons[BTN_TOP_LOW]) begin
            n_pos = POS_TOP_LOW;
        end else if (i_word.buttons[BTN_MIDDLE_TOP]) begin
            n_pos = POS_MIDDLE_TOP;
        end else if (i_word.buttons[BTN_TOP_TOP]) begin
            n_pos = POS_TOP_TOP;
        end else if (i_word.buttons[BTN_GROUND]) begin
            n_pos = POS_GROUND;
        end else if (i_word.buttons[BTN_FOLD]) begin
            n_pos = POS_FOLD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= POS_FOLD;
            r_level   <= LEVEL_DOWN;
            r_transit <= 1'b0;
            r_cnt     <= '0;
            r_vlow    <= 1'b0;
            r_vhigh   <= 1'b0;
            r_elbow   <= '0;
            r_toggle  <= 1'b0;
            r_pressed <= 1'b0;
        end else if (o_take) begin
            r_pos     <= n_pos;
            r_level   <= n_level;
            r_transit <= n_transit;
            r_cnt     <= n_cnt;
            r_vlow    <= n_vlow;
            r_vhigh   <= n_vhigh;
            r_elbow   <= n_elbow;
            r_toggle  <= n_toggle;
            r_pressed <= n_pressed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_take) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_out_word.elbow_target  <= n_elbow;
            r_out_word.low_valve     <= n_vlow;
            r_out_word.high_valve    <= n_vhigh;
            r_out_word.claw_closed   <= n_toggle;
            r_out_word.position_code <= n_pos;
            r_out_word.in_transit    <= n_transit;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.elbow_target  = r_out_word.elbow_target;
    assign o_result.low_valve     = r_out_word.low_valve;
    assign o_result.high_valve    = r_out_word.high_valve;
    assign o_result.claw_closed   = r_out_word.claw_closed;
    assign o_result.position_code = r_out_word.position_code;
    assign o_result.in_transit    = r_out_word.in_transit;

    // A wait starts with the countdown loaded from the transit setting
    a_transit_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_transit) |-> (r_cnt == sat_wait(i_cfg.transit_ticks)))
        else $error("transit started without loading the countdown");

    // The countdown moves only when a word is stepped
    a_cnt_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_take |=> $stable(r_cnt))
        else $error("countdown moved without a stepped word");

    // The latched position is always a real arm position
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos >= POS_MIDDLE_LOW) && (r_pos <= POS_FOLD))
        else $error("latched position out of range");

    // A pending result reflects the state that its step left behind
    a_out_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out_word.position_code == r_pos)
                         && (r_out_word.in_transit == r_transit)
                         && (r_out_word.elbow_target == r_elbow)))
        else $error("pending result disagrees with sequencer state");
endmodule

@@ hdl/arm_position_sequencer.sv @@
// Top level of the arm position sequencer: input register, step logic, configuration.
//
// Each input word is one control tick (buttons, fine-adjust axis, measured arm
// position) and yields exactly one result word: elbow target, both valve states,
// claw state, latched position and transit flag after the tick. The block takes
// a new word every clock cycle while the result side does not stall; an accepted
// word is held in the input register, and the step logic loads its result into
// the result register when it steps the word. The rate is set by the state loop
// of the step logic, which reads the state left by the previous tick and writes
// the next one in the same cycle that the result register loads. Stalls on the
// result side hold the result and then the input register; nothing is lost or
// repeated. Configuration writes are taken every cycle (ready always high) and
// apply from the next tick; write them only while no tick is in flight. Register
// indexes follow the list angle_middle_low, angle_top_low, angle_middle_top,
// angle_top_top, angle_ground, angle_fold, low_level_limit, transit_ticks. There
// is no start-up pass after reset.
module arm_position_sequencer (
    input  logic         i_clk,
    input  logic         i_rst_n,
    aps_item_if.sink     i_item,
    aps_result_if.source o_result,
    aps_cfg_if.sink      i_cfg
);
    import aps_pkg::*;

    t_cfg  cfg;
    t_item in_word;
    logic  in_valid;
    logic  take;

    // Configuration registers, reset to the scaled default angles
    aps_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    // Input register: refilled in the cycle the held word is stepped
    aps_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_take  (take),
        .o_valid (in_valid),
        .o_word  (in_word)
    );

    // Step logic and result register
    aps_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (in_valid),
        .i_word   (in_word),
        .i_cfg    (cfg),
        .o_take   (take),
        .o_result (o_result)
    );
endmodule
